FILE: sv/wave_height_cell_update_defines.svh
// Assertion macros shared by the wave height cell update RTL.
`ifndef WAVE_HEIGHT_CELL_UPDATE_DEFINES_SVH
`define WAVE_HEIGHT_CELL_UPDATE_DEFINES_SVH

// Same-cycle implication, checked on every rising clk outside reset.
`define WHCU_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked on every rising clk outside reset.
`define WHCU_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: sv/whcu_pkg.sv
// Package: widths, register indexes, result type and saturation helper.
`default_nettype none
package whcu_pkg;

	localparam int FRAC_BITS_DEF = 16;
	localparam int WORD_W        = 32;
	localparam int CFG_W         = 31;
	localparam int CFG_IDX_W     = 2;
	localparam int IN_DATA_W     = 320;
	localparam int OUT_DATA_W    = 96;

	localparam logic [CFG_IDX_W-1:0] REG_ZERO_THR   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ARRIVE_THR = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MODEL_TIME = 2'd2;

	// Result item, height in the lowest bits.
	typedef struct packed {
		logic signed [WORD_W-1:0] arrival;
		logic signed [WORD_W-1:0] max_height;
		logic signed [WORD_W-1:0] height;
	} result_t;

	// Clamp a signed value to the signed 32 bit range.
	function automatic logic signed [WORD_W-1:0] sat32(input logic signed [63:0] v);
		logic signed [WORD_W-1:0] r;
		if (v > 64'sh0000_0000_7FFF_FFFF) begin
			r = 32'sh7FFF_FFFF;
		end else if (v < -64'sh0000_0000_8000_0000) begin
			r = -32'sh8000_0000;
		end else begin
			r = v[WORD_W-1:0];
		end
		return r;
	endfunction

endpackage
`default_nettype wire

FILE: sv/whcu_mul.sv
// Registered signed 32 x 32 multiplier with a stage enable.
`default_nettype none
module whcu_mul (
	input  wire logic                                clk,
	input  wire logic                                en,
	input  wire logic signed [whcu_pkg::WORD_W-1:0]  a,
	input  wire logic signed [whcu_pkg::WORD_W-1:0]  b,
	output logic signed [2*whcu_pkg::WORD_W-1:0]     p
);
	import whcu_pkg::*;

	// exact product, held while the pipeline stalls
	always_ff @(posedge clk) begin
		if (en) begin
			p <= a * b;
		end
	end

endmodule
`default_nettype wire

FILE: sv/whcu_skid.sv
// Output register with one skid entry; ready toward the pipeline is registered.
`default_nettype none
module whcu_skid (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	input  wire whcu_pkg::result_t   in_data,
	output logic                     in_ready,
	output logic                     out_valid,
	input  wire logic                out_ready,
	output whcu_pkg::result_t        out_data
);
	import whcu_pkg::*;

	logic    skid_v_q;
	result_t skid_q;
	logic    push;

	assign in_ready = !skid_v_q;
	assign push     = in_valid && !skid_v_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
			skid_v_q  <= 1'b0;
		end else if (skid_v_q) begin
			if (out_ready) begin
				skid_v_q  <= 1'b0;
			end
		end else if (!out_valid || out_ready) begin
			out_valid <= push;
		end else if (push) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_v_q) begin
			if (out_ready) begin
				out_data <= skid_q;
			end
		end else if (!out_valid || out_ready) begin
			if (push) begin
				out_data <= in_data;
			end
		end else if (push) begin
			skid_q <= in_data;
		end
	end

endmodule
`default_nettype wire

FILE: sv/wave_height_cell_update.sv
// A request passes the stage registers, then the output register (via the skid entry when that is full) to m_tdata.
// Throughput: one request per clock; the pipeline stalls as a whole only when its last
// stage holds a result and both the output register and its skid entry are occupied.
// Reset: arst_n clears all valid bits, the skid entry and the three configuration
// registers (thresholds and model time read as zero); data registers are not reset.
`default_nettype none
module wave_height_cell_update #(
	parameter int FRAC_BITS = whcu_pkg::FRAC_BITS_DEF
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	// config write port
	input  wire logic                                 cfg_we,
	input  wire logic [whcu_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  wire logic [whcu_pkg::CFG_W-1:0]           cfg_data,
	// request stream
	input  wire logic                                 s_tvalid,
	output logic                                      s_tready,
	// low to high: height, coef_r1, flux_m_here, flux_m_left, flux_n_here,
	// flux_n_down, coef_row, coef_row_prev, max_height_in, arrival_in (32 bits each)
	input  wire logic [whcu_pkg::IN_DATA_W-1:0]       s_tdata,
	// cell_active
	input  wire logic                                 s_tuser,
	// result stream
	output logic                                      m_tvalid,
	input  wire logic                                 m_tready,
	// low to high: height_out, max_height_out, arrival_out (32 bits each)
	output logic [whcu_pkg::OUT_DATA_W-1:0]           m_tdata
);
	import whcu_pkg::*;

	`include "wave_height_cell_update_defines.svh"

	// ------------------------------------------------------------------
	// Configuration registers; the user must write them only while the
	// block is idle, not enforced by the block, so every stage may read them directly.
	// ------------------------------------------------------------------
	logic [CFG_W-1:0] zero_thr_q;
	logic [CFG_W-1:0] arrive_thr_q;
	logic [CFG_W-1:0] model_time_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			zero_thr_q   <= '0;
			arrive_thr_q <= '0;
			model_time_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_ZERO_THR:   zero_thr_q   <= cfg_data;
				REG_ARRIVE_THR: arrive_thr_q <= cfg_data;
				REG_MODEL_TIME: model_time_q <= cfg_data;
				default:        ;  // unused index: drop the write
			endcase
		end
	end

	// ------------------------------------------------------------------
	// Unpack the request.
	// ------------------------------------------------------------------
	logic signed [WORD_W-1:0] in_h, in_r1, in_fm, in_fml, in_fn, in_fnd;
	logic signed [WORD_W-1:0] in_row, in_rowp, in_max, in_arr;

	assign in_h    = s_tdata[0*WORD_W +: WORD_W];
	assign in_r1   = s_tdata[1*WORD_W +: WORD_W];
	assign in_fm   = s_tdata[2*WORD_W +: WORD_W];
	assign in_fml  = s_tdata[3*WORD_W +: WORD_W];
	assign in_fn   = s_tdata[4*WORD_W +: WORD_W];
	assign in_fnd  = s_tdata[5*WORD_W +: WORD_W];
	assign in_row  = s_tdata[6*WORD_W +: WORD_W];
	assign in_rowp = s_tdata[7*WORD_W +: WORD_W];
	assign in_max  = s_tdata[8*WORD_W +: WORD_W];
	assign in_arr  = s_tdata[9*WORD_W +: WORD_W];

	// ------------------------------------------------------------------
	// Global advance: every stage moves together unless the last stage
	// holds a result that the output side cannot take.
	// ------------------------------------------------------------------
	logic adv;
	logic skid_ready;
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;

	assign adv      = !v_s6 || skid_ready;
	assign s_tready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else if (adv) begin
			v_s1 <= s_tvalid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
		end
	end

	// ------------------------------------------------------------------
	// Stage 1: the two row-metric products, formed exactly.
	// ------------------------------------------------------------------
	logic signed [2*WORD_W-1:0] prod_row_s1, prod_rowp_s1;
	logic                       act_s1;
	logic signed [WORD_W-1:0]   h_s1, r1_s1, fm_s1, fml_s1, max_s1, arr_s1;

	whcu_mul u_mul_row (
		.clk (clk),
		.en  (adv),
		.a   (in_fn),
		.b   (in_row),
		.p   (prod_row_s1)
	);

	whcu_mul u_mul_rowp (
		.clk (clk),
		.en  (adv),
		.a   (in_fnd),
		.b   (in_rowp),
		.p   (prod_rowp_s1)
	);

	always_ff @(posedge clk) begin
		if (adv) begin
			act_s1 <= s_tuser;
			h_s1   <= in_h;
			r1_s1  <= in_r1;
			fm_s1  <= in_fm;
			fml_s1 <= in_fml;
			max_s1 <= in_max;
			arr_s1 <= in_arr;
		end
	end

	// ------------------------------------------------------------------
	// Stage 2: floor-shift and saturate both products; x-flux difference.
	// ------------------------------------------------------------------
	logic signed [WORD_W-1:0] p_row_s2, p_rowp_s2;
	logic signed [WORD_W:0]   dm_s2;
	logic                     act_s2;
	logic signed [WORD_W-1:0] h_s2, r1_s2, max_s2, arr_s2;

	always_ff @(posedge clk) begin
		if (adv) begin
			// arithmetic shift of a signed value rounds toward minus infinity
			p_row_s2  <= sat32(prod_row_s1 >>> FRAC_BITS);
			p_rowp_s2 <= sat32(prod_rowp_s1 >>> FRAC_BITS);
			dm_s2     <= (WORD_W+1)'(fm_s1) - (WORD_W+1)'(fml_s1);
			act_s2    <= act_s1;
			h_s2      <= h_s1;
			r1_s2     <= r1_s1;
			max_s2    <= max_s1;
			arr_s2    <= arr_s1;
		end
	end

	// ------------------------------------------------------------------
	// Stage 3: bracket sum, exact then saturated.
	// ------------------------------------------------------------------
	logic signed [WORD_W+2:0] bsum;
	logic signed [WORD_W-1:0] sum_s3;
	logic                     act_s3;
	logic signed [WORD_W-1:0] h_s3, r1_s3, max_s3, arr_s3;

	assign bsum = (WORD_W+3)'(dm_s2) + (WORD_W+3)'(p_row_s2) - (WORD_W+3)'(p_rowp_s2);

	always_ff @(posedge clk) begin
		if (adv) begin
			sum_s3 <= sat32(64'(bsum));
			act_s3 <= act_s2;
			h_s3   <= h_s2;
			r1_s3  <= r1_s2;
			max_s3 <= max_s2;
			arr_s3 <= arr_s2;
		end
	end

	// ------------------------------------------------------------------
	// Stage 4: continuity coefficient times bracket sum.
	// ------------------------------------------------------------------
	logic signed [2*WORD_W-1:0] prod_r1_s4;
	logic                       act_s4;
	logic signed [WORD_W-1:0]   h_s4, max_s4, arr_s4;

	whcu_mul u_mul_r1 (
		.clk (clk),
		.en  (adv),
		.a   (r1_s3),
		.b   (sum_s3),
		.p   (prod_r1_s4)
	);

	always_ff @(posedge clk) begin
		if (adv) begin
			act_s4 <= act_s3;
			h_s4   <= h_s3;
			max_s4 <= max_s3;
			arr_s4 <= arr_s3;
		end
	end

	// ------------------------------------------------------------------
	// Stage 5: new height = height - sat(r1 * sum), saturated.
	// ------------------------------------------------------------------
	logic signed [WORD_W-1:0] q_r1;
	logic signed [WORD_W:0]   hdiff;
	logic signed [WORD_W-1:0] hh_s5;
	logic                     act_s5;
	logic signed [WORD_W-1:0] h_s5, max_s5, arr_s5;

	assign q_r1  = sat32(prod_r1_s4 >>> FRAC_BITS);
	assign hdiff = (WORD_W+1)'(h_s4) - (WORD_W+1)'(q_r1);

	always_ff @(posedge clk) begin
		if (adv) begin
			hh_s5  <= sat32(64'(hdiff));
			act_s5 <= act_s4;
			h_s5   <= h_s4;
			max_s5 <= max_s4;
			arr_s5 <= arr_s4;
		end
	end

	// ------------------------------------------------------------------
	// Stage 6: magnitude tests, zeroing, running maximum and arrival.
	// Inactive cells pass height, maximum and arrival through untouched.
	// ------------------------------------------------------------------
	logic [WORD_W:0] mag;
	logic            is_zeroed;
	logic            new_max;
	logic            arrived;
	result_t         res_d;
	result_t         res_s6;

	// magnitude in 33 bits so the most negative height keeps its size
	assign mag = hh_s5[WORD_W-1] ? ((WORD_W+1)'(0) - (WORD_W+1)'(hh_s5))
	                             : (WORD_W+1)'(hh_s5);

	assign is_zeroed = mag < (WORD_W+1)'(zero_thr_q);
	assign new_max   = !is_zeroed && (hh_s5 > max_s5);
	// arrival is judged on the magnitude before zeroing; threshold zero disables it
	assign arrived   = (arrive_thr_q != '0) && arr_s5[WORD_W-1] &&
	                   (mag > (WORD_W+1)'(arrive_thr_q));

	always_comb begin
		res_d.height     = h_s5;
		res_d.max_height = max_s5;
		res_d.arrival    = arr_s5;
		if (act_s5) begin
			res_d.height = is_zeroed ? '0 : hh_s5;
			if (new_max) begin
				res_d.max_height = hh_s5;
			end
			if (arrived) begin
				res_d.arrival = signed'(WORD_W'(model_time_q));
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_s6 <= res_d;
		end
	end

	// ------------------------------------------------------------------
	// Output register plus skid entry.
	// ------------------------------------------------------------------
	result_t out_res;

	whcu_skid u_skid (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s6),
		.in_data   (res_s6),
		.in_ready  (skid_ready),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_data  (out_res)
	);

	assign m_tdata = out_res;

	// ------------------------------------------------------------------
	// Checks
	// ------------------------------------------------------------------
	`WHCU_ASSERT_NOW(a_stall_when_full, v_s6 && !skid_ready, !s_tready, "pipeline advanced into a full output")
	`WHCU_ASSERT_NOW(a_skid_implies_out, !skid_ready, m_tvalid, "skid entry occupied with output empty")
	`WHCU_ASSERT_NEXT(a_valid_moves, adv && v_s5, v_s6, "valid lost between stage 5 and stage 6")
	`WHCU_ASSERT_NEXT(a_hold_on_stall, !adv && v_s6, v_s6 && $stable(res_s6), "last stage changed while stalled")

endmodule
`default_nettype wire

FILE: dv/tb_wave_height_cell_update.sv
// Self-checking stream testbench for the wave height cell update block.
`timescale 1ns / 1ps
module tb_wave_height_cell_update;
	import whcu_pkg::*;

	localparam int FRAC           = FRAC_BITS_DEF;
	localparam int RESET_CYCLES   = 12;
	localparam int SETTLE_CYCLES  = 12;     // a little beyond the pipeline latency
	localparam int STALL_CYCLES   = 400;    // long receiver hold-off
	localparam int WATCHDOG_LIMIT = 4000;   // quiet cycles tolerated; longer than the hold-off
	localparam int N_PHASES       = 6;
	localparam int PHASE_ITEMS    = 185;
	localparam int MAX_REPORTS    = 30;

	// Index beyond the register file; the block drops writes to it.
	localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

	localparam logic signed [31:0] ONE  = 32'sh0001_0000;
	localparam logic signed [31:0] HALF = 32'sh0000_8000;
	localparam logic signed [31:0] MAXW = 32'sh7FFF_FFFF;
	localparam logic signed [31:0] MINW = 32'sh8000_0000;
	localparam logic [CFG_W-1:0]   CFG_MAX = 31'h7FFF_FFFF;

	localparam logic signed [63:0] WIDE_MAX = 64'sh0000_0000_7FFF_FFFF;
	localparam logic signed [63:0] WIDE_MIN = 64'shFFFF_FFFF_8000_0000;

	// Request payload as laid out on s_tdata, height in the lowest bits.
	typedef struct packed {
		logic signed [31:0] arrival_in;
		logic signed [31:0] max_height_in;
		logic signed [31:0] coef_row_prev;
		logic signed [31:0] coef_row;
		logic signed [31:0] flux_n_down;
		logic signed [31:0] flux_n_here;
		logic signed [31:0] flux_m_left;
		logic signed [31:0] flux_m_here;
		logic signed [31:0] coef_r1;
		logic signed [31:0] height;
	} cell_data_t;

	typedef struct packed {
		logic       active;
		cell_data_t d;
	} cell_req_t;

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_W-1:0]      cfg_data  = '0;
	logic                  s_tvalid  = 1'b0;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata   = '0;
	logic                  s_tuser   = 1'b0;
	logic                  m_tvalid;
	logic                  m_tready  = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;

	wave_height_cell_update DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	// Shadow copy of the configuration registers.
	logic [CFG_W-1:0] zero_thr_q    = '0;
	logic [CFG_W-1:0] arrive_thr_q  = '0;
	logic [CFG_W-1:0] model_time_q  = '0;

	cell_req_t cell_req_q[$];      // requests waiting for the driver
	result_t   cell_result_q[$];   // predicted results, oldest first
	cell_req_t req_on_bus;         // request currently offered on s_tdata

	int unsigned send_idle_pct = 34;
	int unsigned recv_idle_pct = 59;
	bit          hold_arm  = 1'b0;
	bit          hold_done = 1'b0;
	logic        recv_hold = 1'b0;
	int          hold_left = 0;

	int mismatches    = 0;
	int reqs_accepted = 0;
	int inactive_seen = 0;
	int zeroed_seen   = 0;
	int arrivals_seen = 0;
	int results_seen  = 0;
	int quiet_cycles  = 0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ---------------------------------------------------------------
	// Prediction
	// ---------------------------------------------------------------

	// Clamp an exact wide value to the signed 32 bit range.
	function automatic logic signed [63:0] clamp_word(input logic signed [63:0] v);
		logic signed [63:0] r;
		if (v > WIDE_MAX) begin
			r = WIDE_MAX;
		end else if (v < WIDE_MIN) begin
			r = WIDE_MIN;
		end else begin
			r = v;
		end
		return r;
	endfunction

	// Fixed-point product: exact, floor shift by FRAC, then clamp.
	function automatic logic signed [63:0] q_product(input logic signed [31:0] a,
			input logic signed [31:0] b);
		logic signed [63:0] wa;
		logic signed [63:0] wb;
		logic signed [63:0] prod;
		wa = 64'(a);
		wb = 64'(b);
		prod = wa * wb;
		return clamp_word(prod >>> FRAC);
	endfunction

	// Work out the result for one cell against the shadow registers.
	function automatic result_t update_cell(input cell_req_t c, output bit zeroed,
			output bit arrived);
		logic signed [63:0] h;
		logic signed [63:0] fm;
		logic signed [63:0] fml;
		logic signed [63:0] sum;
		logic signed [63:0] mag;
		logic signed [63:0] hmax;
		logic signed [63:0] tarr;
		result_t r;
		zeroed  = 1'b0;
		arrived = 1'b0;
		h    = 64'(c.d.height);
		hmax = 64'(c.d.max_height_in);
		tarr = 64'(c.d.arrival_in);
		if (c.active) begin
			fm  = 64'(c.d.flux_m_here);
			fml = 64'(c.d.flux_m_left);
			sum = clamp_word(fm - fml + q_product(c.d.flux_n_here, c.d.coef_row)
				- q_product(c.d.flux_n_down, c.d.coef_row_prev));
			h = clamp_word(h - q_product(c.d.coef_r1, sum[31:0]));
			// magnitude is exact: -2^31 gives 2^31
			mag = (h < 0) ? -h : h;
			if (mag < $signed({33'd0, zero_thr_q})) begin
				h = '0;
				zeroed = 1'b1;
			end else if (h > hmax) begin
				hmax = h;
			end
			// arrival uses the magnitude before any zeroing, and is recorded only once
			if (arrive_thr_q != '0 && tarr < 0 && mag > $signed({33'd0, arrive_thr_q})) begin
				tarr = $signed({33'd0, model_time_q});
				arrived = 1'b1;
			end
		end
		r.height     = h[31:0];
		r.max_height = hmax[31:0];
		r.arrival    = tarr[31:0];
		return r;
	endfunction

	// ---------------------------------------------------------------
	// Stimulus helpers
	// ---------------------------------------------------------------

	function automatic cell_req_t make_req(input logic act, input logic signed [31:0] h,
			input logic signed [31:0] r1, input logic signed [31:0] fm,
			input logic signed [31:0] fml, input logic signed [31:0] fn,
			input logic signed [31:0] fnd, input logic signed [31:0] row,
			input logic signed [31:0] rowp, input logic signed [31:0] hmax,
			input logic signed [31:0] tarr);
		cell_req_t c;
		c.active          = act;
		c.d.height        = h;
		c.d.coef_r1       = r1;
		c.d.flux_m_here   = fm;
		c.d.flux_m_left   = fml;
		c.d.flux_n_here   = fn;
		c.d.flux_n_down   = fnd;
		c.d.coef_row      = row;
		c.d.coef_row_prev = rowp;
		c.d.max_height_in = hmax;
		c.d.arrival_in    = tarr;
		return c;
	endfunction

	// Mix of full-range words, extremes and words of every magnitude.
	function automatic logic signed [31:0] rand_word();
		logic signed [31:0] w;
		case ($urandom_range(7))
			0, 1: begin
				w = $urandom;
			end
			2: begin
				case ($urandom_range(4))
					0: w = MINW;
					1: w = MAXW;
					2: w = 0;
					3: w = -1;
					default: w = 1;
				endcase
			end
			default: begin
				w = $signed($urandom) >>> $urandom_range(6, 30);
			end
		endcase
		return w;
	endfunction

	function automatic cell_req_t rand_req();
		return make_req($urandom_range(99) < 85, rand_word(), rand_word(), rand_word(),
			rand_word(), rand_word(), rand_word(), rand_word(), rand_word(), rand_word(),
			rand_word());
	endfunction

	// Full-range or small threshold, so both zeroing outcomes stay common.
	function automatic logic [CFG_W-1:0] rand_thr();
		logic [CFG_W-1:0] v;
		if ($urandom_range(1)) begin
			v = CFG_W'($urandom);
		end else begin
			v = CFG_W'($urandom_range(0, 32'h0004_0000));
		end
		return v;
	endfunction

	// Write one register at the next rising edge; caller lowers cfg_we.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		case (idx)
			REG_ZERO_THR:   zero_thr_q   = val;
			REG_ARRIVE_THR: arrive_thr_q = val;
			REG_MODEL_TIME: model_time_q = val;
			default: ;
		endcase
	endtask

	task automatic program_regs(input logic [CFG_W-1:0] zt, input logic [CFG_W-1:0] at,
			input logic [CFG_W-1:0] mt);
		write_reg(REG_ZERO_THR, zt);
		write_reg(REG_ARRIVE_THR, at);
		write_reg(REG_MODEL_TIME, mt);
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// Wait until every request is sent and every predicted result is back, then let the pipe settle.
	task automatic wait_drained();
		while (cell_req_q.size() != 0 || s_tvalid || cell_result_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		if (mismatches < MAX_REPORTS)
			$display("MISMATCH @%0t %s: got %h want %h", $realtime, what, got, want);
		mismatches++;
	endtask

	// ---------------------------------------------------------------
	// Driver: offer pending requests, predict each one on accept
	// ---------------------------------------------------------------
	always @(posedge clk) begin : drive_cells
		cell_req_t nxt;
		result_t   want;
		bit        zeroed;
		bit        arrived;
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				want = update_cell(req_on_bus, zeroed, arrived);
				cell_result_q.push_back(want);
				reqs_accepted++;
				if (!req_on_bus.active)
					inactive_seen++;
				if (zeroed)
					zeroed_seen++;
				if (arrived)
					arrivals_seen++;
			end
			// advance only when the bus is free or the current request just went in
			if (!s_tvalid || s_tready) begin
				if (cell_req_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					nxt = cell_req_q.pop_front();
					req_on_bus <= nxt;
					s_tvalid   <= 1'b1;
					s_tdata    <= nxt.d;
					s_tuser    <= nxt.active;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// ---------------------------------------------------------------
	// Monitor: compare every accepted result with the oldest prediction
	// ---------------------------------------------------------------
	always @(posedge clk) begin : check_results
		result_t got;
		result_t want;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				got = m_tdata;
				results_seen++;
				if (cell_result_q.size() == 0) begin
					report_mismatch("result with no request pending", got.height, '0);
				end else begin
					want = cell_result_q.pop_front();
					if (got.height !== want.height)
						report_mismatch("height_out", got.height, want.height);
					if (got.max_height !== want.max_height)
						report_mismatch("max_height_out", got.max_height, want.max_height);
					if (got.arrival !== want.arrival)
						report_mismatch("arrival_out", got.arrival, want.arrival);
				end
			end
			m_tready <= !recv_hold && ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// Long receiver hold-off, counted here so the sender keeps offering meanwhile.
	always @(posedge clk) begin
		if (arst_n) begin
			if (hold_left != 0) begin
				hold_left <= hold_left - 1;
				if (hold_left == 1)
					recv_hold <= 1'b0;
			end else if (hold_arm && !hold_done) begin
				recv_hold <= 1'b1;
				hold_left <= STALL_CYCLES;
				hold_done <= 1'b1;
			end
		end
	end

	// Watchdog: end the run if nothing moves for too long.
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("timeout: no handshake for %0d cycles", WATCHDOG_LIMIT);
			$display("tb_wave_height_cell_update: errors");
			$finish;
		end
	end

	// ---------------------------------------------------------------
	// Sequence: reset, directed corners, then random phases
	// ---------------------------------------------------------------
	initial begin
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// zero threshold above the arrival threshold, so a cell can be zeroed and arrive
		program_regs(CFG_W'(ONE), CFG_W'(HALF), 31'd1234);

		// inactive cells pass through untouched
		cell_req_q.push_back(make_req(0, MAXW, MINW, 7, 8, 9, 10, 11, 12, MINW, -1));
		cell_req_q.push_back(make_req(0, MINW, MAXW, MAXW, MINW, MAXW, MINW, MAXW, MINW,
			MAXW, MAXW));
		// all zero: zeroed, no arrival
		cell_req_q.push_back(make_req(1, 0, 0, 0, 0, 0, 0, 0, 0, 0, -1));
		// magnitude exactly at the zero threshold: kept, raises max, arrives
		cell_req_q.push_back(make_req(1, 2 * ONE, HALF, ONE, 0, ONE, 0, ONE, 0, 0, -1));
		// zeroed but above arrival threshold: max untouched, arrival recorded
		cell_req_q.push_back(make_req(1, 32'sh0000_C000, 0, 0, 0, 0, 0, 0, 0, -ONE, -5));
		// magnitude exactly at the arrival threshold: no arrival
		cell_req_q.push_back(make_req(1, HALF, 0, 0, 0, 0, 0, 0, 0, 0, -1));
		cell_req_q.push_back(make_req(1, -32'sh0000_FFFF, 0, 0, 0, 0, 0, 0, 0, MINW, MINW));
		// arrival already recorded stays as it is
		cell_req_q.push_back(make_req(1, 5 * ONE, 0, 0, 0, 0, 0, 0, 0, 0, 0));
		cell_req_q.push_back(make_req(1, 5 * ONE, 0, 0, 0, 0, 0, 0, 0, MAXW, MAXW));
		// height equal to and below the stored maximum
		cell_req_q.push_back(make_req(1, 3 * ONE, 0, 0, 0, 0, 0, 0, 0, 3 * ONE, -1));
		cell_req_q.push_back(make_req(1, 3 * ONE, 0, 0, 0, 0, 0, 0, 0, 4 * ONE, -1));
		// most negative height: magnitude 2^31
		cell_req_q.push_back(make_req(1, MINW, 0, 0, 0, 0, 0, 0, 0, MINW, MINW));
		// product saturation both ways, and the min*min corner
		cell_req_q.push_back(make_req(1, 0, ONE, 0, 0, MAXW, 0, MAXW, 0, 0, -1));
		cell_req_q.push_back(make_req(1, 0, ONE, 0, 0, MINW, 0, MAXW, 0, 0, -1));
		cell_req_q.push_back(make_req(1, 0, ONE, 0, 0, 0, MINW, 0, MINW, 0, -1));
		// floor rounding of small negative products
		cell_req_q.push_back(make_req(1, 7 * ONE, ONE, 0, 0, -1, -1, 1, 1, 0, -1));
		cell_req_q.push_back(make_req(1, 7 * ONE, ONE, 0, 0, -1, 0, 1, 0, 0, -1));
		// bracket sum saturation both ways
		cell_req_q.push_back(make_req(1, 0, -ONE, MAXW, MINW, 0, 0, 0, 0, 0, -1));
		cell_req_q.push_back(make_req(1, 0, -ONE, MINW, MAXW, 0, 0, 0, 0, 0, -1));
		// final difference saturation both ways
		cell_req_q.push_back(make_req(1, MAXW, MINW, MAXW, 0, 0, 0, 0, 0, 0, -1));
		cell_req_q.push_back(make_req(1, MINW, MAXW, MAXW, 0, 0, 0, 0, 0, 0, -1));
		// every field at one extreme
		cell_req_q.push_back(make_req(1, -1, -1, -1, -1, -1, -1, -1, -1, -1, -1));
		cell_req_q.push_back(make_req(1, MINW, MINW, MINW, MINW, MINW, MINW, MINW, MINW,
			MINW, MINW));
		cell_req_q.push_back(make_req(1, MAXW, MAXW, MAXW, MAXW, MAXW, MAXW, MAXW, MAXW,
			MAXW, MAXW));

		for (int ph = 0; ph < N_PHASES; ph++) begin
			wait_drained();
			case (ph)
				0: begin
					// thresholds off, arrival disabled
					program_regs('0, '0, CFG_MAX);
				end
				1: begin
					send_idle_pct = 59;
					recv_idle_pct = 34;
					program_regs(CFG_MAX, CFG_MAX, '0);
				end
				2: begin
					// out-of-range index goes first; the block must drop it
					write_reg(REG_SPARE, CFG_W'($urandom));
					program_regs(rand_thr(), rand_thr(), CFG_W'($urandom));
				end
				3: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
					program_regs(CFG_W'($urandom_range(0, 32'h0000_4000)), 31'd1,
						CFG_W'($urandom));
					hold_arm = 1'b1;
				end
				default: begin
					program_regs(rand_thr(), rand_thr(), CFG_W'($urandom));
				end
			endcase
			repeat (PHASE_ITEMS) cell_req_q.push_back(rand_req());
		end

		wait_drained();
		$display("%0d cells checked: %0d inactive, %0d zeroed, %0d arrivals recorded",
			results_seen, inactive_seen, zeroed_seen, arrivals_seen);
		$display("register sets: all-zero, all-max, random, tiny; one %0d-cycle output stall",
			STALL_CYCLES);
		if (mismatches == 0) begin
			$display("tb_wave_height_cell_update: clean");
		end else begin
			$display("%0d mismatches", mismatches);
			$display("tb_wave_height_cell_update: errors");
		end
		$finish;
	end

endmodule
